// ----- hw/rtl/brd_pkg.sv -----
// brd_pkg: shared types, reset values and register indexes of the bitmap row deframer
// no dependencies
`timescale 1ns / 1ps

package brd_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int CFG_DW = 32;
    localparam int CFG_AW = 4;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BPP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    localparam logic [12:0] WIDTH_RST  = 13'd1;
    localparam logic [12:0] HEIGHT_RST = 13'd1;
    localparam logic [2:0]  BPP_RST    = 3'd3;
    localparam logic        BOTTOM_RST = 1'b1;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic        bottom_up;
    } t_cfg;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  reserved_byte;
        logic        end_of_image;
    } t_pix;

endpackage

// ----- hw/rtl/bmp_byte_if.sv -----
// bmp_byte_if: valid/ready channel carrying one byte of the pixel array
// no dependencies
`timescale 1ns / 1ps

interface bmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hw/rtl/bmp_pix_if.sv -----
// bmp_pix_if: valid/ready channel carrying one pixel with its coordinates
// no dependencies
`timescale 1ns / 1ps

interface bmp_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  reserved_byte;
    logic        end_of_image;

    modport source (output valid, output pixel_column, output pixel_row, output blue,
                    output green, output red, output reserved_byte, output end_of_image,
                    input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, input blue,
                    input green, input red, input reserved_byte, input end_of_image,
                    output ready);
endinterface

// ----- hw/rtl/brd_regs.sv -----
// brd_regs: apb-style configuration registers of the deframer
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [brd_pkg::CFG_AW-1:0] i_paddr,
    input  logic [brd_pkg::CFG_DW-1:0] i_pwdata,
    output logic [brd_pkg::CFG_DW-1:0] o_prdata,
    output logic                      o_pready,
    output brd_pkg::t_cfg             o_cfg
);
    import brd_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign reg_idx  = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= WIDTH_RST;
            r_cfg.image_height    <= HEIGHT_RST;
            r_cfg.bytes_per_pixel <= BPP_RST;
            r_cfg.bottom_up       <= BOTTOM_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  r_cfg.image_width     <= i_pwdata[12:0];
                REG_HEIGHT: r_cfg.image_height    <= i_pwdata[12:0];
                REG_BPP:    r_cfg.bytes_per_pixel <= i_pwdata[2:0];
                REG_BOTTOM: r_cfg.bottom_up       <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  o_prdata = {19'd0, r_cfg.image_width};
            REG_HEIGHT: o_prdata = {19'd0, r_cfg.image_height};
            REG_BPP:    o_prdata = {29'd0, r_cfg.bytes_per_pixel};
            REG_BOTTOM: o_prdata = {31'd0, r_cfg.bottom_up};
            default:    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/brd_core.sv -----
// brd_core: byte gathering, padding drop and column/row counters
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_core #(
    parameter int MAX_DIM = brd_pkg::MAX_DIM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  brd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    output logic          o_valid,
    output brd_pkg::t_pix o_pix
);
    import brd_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);

    logic [1:0]    r_bip, n_bip;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [1:0]    r_pad, n_pad;
    logic [23:0]   r_part, n_part;

    logic [DW-1:0] w_eff, h_eff;
    logic [2:0]    bpp_eff;
    logic [31:0]   byte_sh;
    logic [31:0]   pix;
    logic [31:0]   row_flip;
    logic [31:0]   col_ext;
    logic [31:0]   row_ext;
    logic [1:0]    row_bytes;
    logic [DW-1:0] col_next;
    logic [DW-1:0] row_next;

    // zero counts as one, oversize clamps to the maximum dimension (bytes per pixel to four)
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_eff = DW'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_DIM)) begin
            w_eff = DW'(MAX_DIM);
        end else begin
            w_eff = DW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h_eff = DW'(1);
        end else if (32'(i_cfg.image_height) > 32'(MAX_DIM)) begin
            h_eff = DW'(MAX_DIM);
        end else begin
            h_eff = DW'(i_cfg.image_height);
        end
        if (i_cfg.bytes_per_pixel == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (i_cfg.bytes_per_pixel > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = i_cfg.bytes_per_pixel;
        end
    end

    assign byte_sh   = {24'd0, i_data_byte} << {r_bip, 3'b000};
    assign pix       = {8'd0, r_part} | byte_sh;
    assign col_ext   = 32'(r_col);
    assign row_ext   = 32'(r_row);
    // row flip wraps modulo the 12-bit output when the row lies past the height
    assign row_flip  = 32'(h_eff) - 32'd1 - row_ext;
    assign row_bytes = 2'(w_eff[1:0] * bpp_eff[1:0]);
    assign col_next  = DW'(r_col) + DW'(1);
    assign row_next  = DW'(r_row) + DW'(1);

    always_comb begin
        n_bip   = r_bip;
        n_col   = r_col;
        n_row   = r_row;
        n_pad   = r_pad;
        n_part  = r_part;
        o_valid = 1'b0;
        o_pix   = '0;
        if (i_valid) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if ({1'b0, r_bip} + 3'd1 < bpp_eff) begin
                n_part = r_part | byte_sh[23:0];
                n_bip  = r_bip + 2'd1;
            end else begin
                n_part  = '0;
                n_bip   = '0;
                o_valid = 1'b1;
                o_pix.pixel_column  = col_ext[11:0];
                o_pix.pixel_row     = i_cfg.bottom_up ? row_flip[11:0] : row_ext[11:0];
                o_pix.blue          = pix[7:0];
                o_pix.green         = pix[15:8];
                o_pix.red           = pix[23:16];
                o_pix.reserved_byte = pix[31:24];
                if (col_next >= w_eff) begin
                    n_col = '0;
                    n_pad = 2'd0 - row_bytes;
                    if (row_next >= h_eff) begin
                        n_row = '0;
                        o_pix.end_of_image = 1'b1;
                    end else begin
                        n_row = row_next[CW-1:0];
                    end
                end else begin
                    n_col = col_next[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bip  <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_pad  <= '0;
            r_part <= '0;
        end else begin
            r_bip  <= n_bip;
            r_col  <= n_col;
            r_row  <= n_row;
            r_pad  <= n_pad;
            r_part <= n_part;
        end
    end

endmodule

// ----- hw/rtl/brd_outbuf.sv -----
// brd_outbuf: two-entry result register that decouples the pixel output from the byte input
// depends on brd_pkg
`timescale 1ns / 1ps

module brd_outbuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brd_pkg::t_pix i_pix,
    output logic          o_not_full,
    output logic          o_valid,
    input  logic          i_ready,
    output brd_pkg::t_pix o_pix
);
    import brd_pkg::*;

    t_pix       r_buf [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid    = (r_count != 2'd0);
    assign o_not_full = (r_count != 2'd2);
    assign pop        = o_valid & i_ready;
    assign o_pix      = r_buf[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_pix;
        end
    end

endmodule

// ----- hw/rtl/bmp_row_deframer_top.sv -----
// bmp_row_deframer_top: bitmap pixel array deframer, one byte in per cycle unless stalled
// output: a pixel enters the result buffer as its last byte is taken and is offered from it
// throughput: one byte per cycle; the two-entry result buffer holds input off only when full
// reset: synchronous active-low; counters, gathered bytes and buffer clear, registers
// return to width 1, height 1, three bytes per pixel, bottom-up
// depends on brd_pkg, bmp_byte_if, bmp_pix_if, brd_regs, brd_core, brd_outbuf
`timescale 1ns / 1ps

module bmp_row_deframer_top #(
    parameter int MAX_DIM = brd_pkg::MAX_DIM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bmp_byte_if.sink                   i_byte,
    bmp_pix_if.source                  o_pix,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [brd_pkg::CFG_AW-1:0] i_paddr,
    input  logic [brd_pkg::CFG_DW-1:0] i_pwdata,
    output logic [brd_pkg::CFG_DW-1:0] o_prdata,
    output logic                       o_pready
);
    import brd_pkg::*;

    t_cfg cfg;
    t_pix core_pix;
    t_pix buf_pix;
    logic core_valid;
    logic buf_not_full;
    logic accept;

    assign i_byte.ready = buf_not_full;
    assign accept       = i_byte.valid & buf_not_full;

    brd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    brd_core #(.MAX_DIM(MAX_DIM)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (accept),
        .i_data_byte (i_byte.data_byte),
        .o_valid     (core_valid),
        .o_pix       (core_pix)
    );

    brd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (core_valid),
        .i_pix      (core_pix),
        .o_not_full (buf_not_full),
        .o_valid    (o_pix.valid),
        .i_ready    (o_pix.ready),
        .o_pix      (buf_pix)
    );

    assign o_pix.pixel_column  = buf_pix.pixel_column;
    assign o_pix.pixel_row     = buf_pix.pixel_row;
    assign o_pix.blue          = buf_pix.blue;
    assign o_pix.green         = buf_pix.green;
    assign o_pix.red           = buf_pix.red;
    assign o_pix.reserved_byte = buf_pix.reserved_byte;
    assign o_pix.end_of_image  = buf_pix.end_of_image;

endmodule

// ----- hw/rtl/brd_checker.sv -----
// brd_checker: port-level assertions for the deframer top level, with its bind
// depends on bmp_row_deframer_top
`timescale 1ns / 1ps

module brd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_out_column,
    input logic [11:0] i_out_row,
    input logic        i_out_eoi,
    input logic        i_pready
);

    // a stalled pixel word keeps its coordinates
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_column)
            && $stable(i_out_row) && $stable(i_out_eoi))
        else $error("stalled pixel word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel word offered straight after reset");

    // input back-pressure only comes from a full result buffer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("byte input stalled with no pending pixel");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("configuration port not ready");

endmodule

bind bmp_row_deframer_top brd_checker u_brd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_byte.ready),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_out_column (o_pix.pixel_column),
    .i_out_row    (o_pix.pixel_row),
    .i_out_eoi    (o_pix.end_of_image),
    .i_pready     (o_pready)
);
